>>> rtl/adsr_envelope_gain_macros.svh
// Assertion macros shared by the envelope gain RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ADSR_ENVELOPE_GAIN_MACROS_SVH
`define ADSR_ENVELOPE_GAIN_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk, quiet during reset.
`define ADSR_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ADSR_ASSERT(label, ante, cons, msg)
`define ADSR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/adsr_pkg.sv
package adsr_pkg;

    localparam int CfgWidth    = 17;
    localparam int LevelWidth  = 18;
    localparam int SampleWidth = 32;
    localparam int ProdWidth   = SampleWidth + LevelWidth;
    localparam int FracBits    = 16;
    localparam int AddrWidth   = 4;
    localparam int DataWidth   = 32;

    localparam logic signed [LevelWidth-1:0] LevelOne = 18'sd65536;
    localparam logic signed [LevelWidth-1:0] LevelMin = -18'sd65536;
    localparam logic signed [19:0] ReleaseFloor = 20'sd655;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_ATTACK_STEP   = 2'd0;
    localparam logic [1:0] REG_DECAY_STEP    = 2'd1;
    localparam logic [1:0] REG_SUSTAIN_LEVEL = 2'd2;
    localparam logic [1:0] REG_RELEASE_COEF  = 2'd3;

    // Trigger codes carried with each sample
    localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd2;

    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [CfgWidth-1:0] attack_step;
        logic [CfgWidth-1:0] decay_step;
        logic [CfgWidth-1:0] sustain_level;
        logic [CfgWidth-1:0] release_coef;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic update_level;
        logic mul_sample;
        logic mul_en;
        logic load_out;
    } cmd_t;

endpackage

>>> rtl/adsr_cfg.sv
module adsr_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adsr_pkg::AddrWidth-1:0] paddr,
    input  logic [adsr_pkg::DataWidth-1:0] pwdata,
    output logic [adsr_pkg::DataWidth-1:0] prdata,
    output logic                          pready,
    output adsr_pkg::cfg_t                cfg
);
    import adsr_pkg::*;

    logic [CfgWidth-1:0] attack_step_reg;
    logic [CfgWidth-1:0] decay_step_reg;
    logic [CfgWidth-1:0] sustain_level_reg;
    logic [CfgWidth-1:0] release_coef_reg;
    logic [1:0]          reg_index;
    logic                wr_en;

    assign reg_index = paddr[3:2];
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg   <= 17'd655;
            decay_step_reg    <= 17'd65;
            sustain_level_reg <= 17'd45875;
            release_coef_reg  <= 17'd65;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_ATTACK_STEP:   attack_step_reg   <= pwdata[CfgWidth-1:0];
                REG_DECAY_STEP:    decay_step_reg    <= pwdata[CfgWidth-1:0];
                REG_SUSTAIN_LEVEL: sustain_level_reg <= pwdata[CfgWidth-1:0];
                REG_RELEASE_COEF:  release_coef_reg  <= pwdata[CfgWidth-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_ATTACK_STEP:   prdata = {{(DataWidth-CfgWidth){1'b0}}, attack_step_reg};
            REG_DECAY_STEP:    prdata = {{(DataWidth-CfgWidth){1'b0}}, decay_step_reg};
            REG_SUSTAIN_LEVEL: prdata = {{(DataWidth-CfgWidth){1'b0}}, sustain_level_reg};
            REG_RELEASE_COEF:  prdata = {{(DataWidth-CfgWidth){1'b0}}, release_coef_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.attack_step   = attack_step_reg;
    assign cfg.decay_step    = decay_step_reg;
    assign cfg.sustain_level = sustain_level_reg;
    assign cfg.release_coef  = release_coef_reg;

endmodule

>>> rtl/adsr_ctrl.sv
`include "adsr_envelope_gain_macros.svh"

module adsr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output adsr_pkg::cmd_t cmd
);
    import adsr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_LEVEL;
            ST_LEVEL: state_next = ST_MUL;
            ST_MUL:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        cmd.load_in      = 1'b0;
        cmd.update_level = 1'b0;
        cmd.mul_sample   = 1'b0;
        cmd.mul_en       = 1'b1;
        cmd.load_out     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_LEVEL: cmd.update_level = 1'b1;
            ST_MUL:   cmd.mul_sample   = 1'b1;
            ST_OUT:
            begin
                // hold the sample product until the output slot takes it
                cmd.mul_en   = out_free;
                cmd.load_out = out_free;
            end
            default:  ;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ADSR_ASSERT_NEXT(a_accept_starts_update, state_reg == ST_IDLE && in_valid, state_reg == ST_LEVEL, "accepted request did not start a level update")
    `ADSR_ASSERT_NEXT(a_level_then_mul, state_reg == ST_LEVEL, state_reg == ST_MUL, "level update not followed by sample multiply")
    `ADSR_ASSERT_NEXT(a_result_posted, state_reg == ST_OUT && !out_valid_reg, out_valid_reg && state_reg == ST_IDLE, "free output slot not filled")

endmodule

>>> rtl/adsr_dp.sv
`include "adsr_envelope_gain_macros.svh"

module adsr_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  adsr_pkg::cmd_t                         cmd,
    input  adsr_pkg::cfg_t                         cfg,
    input  logic signed [adsr_pkg::SampleWidth-1:0] sample_in,
    input  logic [1:0]                             mode,
    output logic signed [adsr_pkg::SampleWidth-1:0] sample_out
);
    import adsr_pkg::*;

    localparam int RndWidth = ProdWidth - FracBits;

    logic signed [SampleWidth-1:0] sample_reg;
    logic [1:0]                    mode_reg;
    logic signed [ProdWidth-1:0]   prod_reg;
    logic signed [SampleWidth-1:0] sample_out_reg;
    phase_t                        phase_reg;
    phase_t                        phase_next;
    logic signed [LevelWidth-1:0]  level_reg;
    logic signed [LevelWidth-1:0]  level_next;

    logic signed [SampleWidth-1:0] mul_a;
    logic signed [LevelWidth-1:0]  mul_b;
    logic signed [ProdWidth-1:0]   prod;
    logic signed [ProdWidth-1:0]   rnd_sum;
    logic signed [RndWidth-1:0]    rnd;
    logic signed [SampleWidth-1:0] sat_out;

    phase_t                        eff_phase;
    logic signed [LevelWidth:0]    att_sum;
    logic signed [LevelWidth:0]    dec_diff;
    logic signed [19:0]            rel_level;

    // One shared multiplier: level times release fraction, or sample times level
    assign mul_a = cmd.mul_sample ? sample_reg
                                  : {{(SampleWidth-LevelWidth){level_reg[LevelWidth-1]}},
                                     level_reg};
    assign mul_b = cmd.mul_sample ? level_reg
                                  : $signed({{(LevelWidth-CfgWidth){1'b0}}, cfg.release_coef});
    assign prod  = mul_a * mul_b;

    // Round to nearest, ties away from zero
    assign rnd_sum = prod_reg + (prod_reg[ProdWidth-1] ? ProdWidth'(32'sh7FFF)
                                                       : ProdWidth'(32'sh8000));
    assign rnd     = rnd_sum[ProdWidth-1:FracBits];

    always_comb
    begin
        if (rnd[RndWidth-1:SampleWidth-1] != {(RndWidth-SampleWidth+1){rnd[RndWidth-1]}})
            sat_out = rnd[RndWidth-1] ? {1'b1, {(SampleWidth-1){1'b0}}}
                                      : {1'b0, {(SampleWidth-1){1'b1}}};
        else
            sat_out = rnd[SampleWidth-1:0];
    end

    always_comb
    begin
        if (mode_reg == MODE_NOTE_ON)
            eff_phase = PH_ATTACK;
        else if (mode_reg == MODE_NOTE_OFF)
            eff_phase = PH_RELEASE;
        else
            eff_phase = phase_reg;
    end

    assign att_sum   = {level_reg[LevelWidth-1], level_reg}
                     + $signed({2'b00, cfg.attack_step});
    assign dec_diff  = {level_reg[LevelWidth-1], level_reg}
                     - $signed({2'b00, cfg.decay_step});
    assign rel_level = {{2{level_reg[LevelWidth-1]}}, level_reg} - rnd[19:0];

    always_comb
    begin
        phase_next = eff_phase;
        level_next = level_reg;
        case (eff_phase)
            PH_ATTACK:
            begin
                if (att_sum >= $signed({LevelOne[LevelWidth-1], LevelOne}))
                begin
                    level_next = LevelOne;
                    phase_next = PH_DECAY;
                end
                else
                    level_next = att_sum[LevelWidth-1:0];
            end
            PH_DECAY:
            begin
                // no clamp at the sustain level: undershoot is kept
                level_next = dec_diff[LevelWidth-1:0];
                if (dec_diff <= $signed({2'b00, cfg.sustain_level}))
                    phase_next = PH_SUSTAIN;
            end
            PH_SUSTAIN: ;
            PH_RELEASE:
            begin
                if (rel_level < ReleaseFloor)
                begin
                    level_next = '0;
                    phase_next = PH_OFF;
                end
                else
                    level_next = rel_level[LevelWidth-1:0];
            end
            default:
            begin
                level_next = '0;
                phase_next = PH_OFF;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OFF;
            level_reg <= '0;
        end
        else if (cmd.update_level)
        begin
            phase_reg <= phase_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg <= sample_in;
            mode_reg   <= mode;
        end
        if (cmd.mul_en)
            prod_reg <= prod;
        if (cmd.load_out)
            sample_out_reg <= sat_out;
    end

    assign sample_out = sample_out_reg;

    `ADSR_ASSERT(a_level_range, 1'b1, level_reg >= LevelMin && level_reg <= LevelOne, "envelope level out of range")
    `ADSR_ASSERT(a_off_is_silent, phase_reg == PH_OFF, level_reg == '0, "off phase with nonzero level")
    `ADSR_ASSERT(a_attack_below_one, phase_reg == PH_ATTACK, level_reg < LevelOne, "attack kept a level at full scale")

endmodule

>>> rtl/adsr_envelope_gain.sv
// ADSR envelope gain stage in Q16.16. Each request carries one signed sample and
// a trigger (note on enters attack, note off enters release, other codes leave
// the phase alone); the envelope advances one step and the sample leaves scaled
// by the new amplitude, rounded to nearest and saturated to 32 bits. A request
// passes through accept, envelope update, sample multiply and result post; the
// post waits while the output register is still full. One 32x18 signed
// multiplier is shared by the release product and the sample product. A finished
// result waits in the output register while the next request is accepted.
// Registers on the APB port: 0x0 attack_step, 0x4 decay_step, 0x8 sustain_level,
// 0xC release_coef, all 17-bit Q1.16; write them only while no request is
// in flight.
module adsr_envelope_gain (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [adsr_pkg::AddrWidth-1:0]          paddr,
    input  logic [adsr_pkg::DataWidth-1:0]          pwdata,
    output logic [adsr_pkg::DataWidth-1:0]          prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [adsr_pkg::SampleWidth-1:0] sample_in,
    input  logic [1:0]                             mode,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [adsr_pkg::SampleWidth-1:0] sample_out
);
    import adsr_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    adsr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    adsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    adsr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .sample_in  (sample_in),
        .mode       (mode),
        .sample_out (sample_out)
    );

endmodule
